// File: rtl/core/gmt_pkg.sv
// Shared types and codes for the grid map tracker.
// Used by the sweep engine, the top level and the port checker; no dependencies.
package gmt_pkg;

	// Packed stream widths, padded to whole bytes.
	localparam int IN_W  = 24;
	localparam int OUT_W = 16;

	typedef enum logic [2:0] {
		ACT_RESET   = 3'd0,
		ACT_TURN    = 3'd1,
		ACT_ADVANCE = 3'd2,
		ACT_RECORD  = 3'd3,
		ACT_READ    = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		TURN_RIGHT = 2'd0,
		TURN_LEFT  = 2'd1,
		TURN_ABOUT = 2'd2,
		TURN_HOLD  = 2'd3
	} turn_t;

	typedef enum logic [1:0] {
		HEAD_N = 2'd0,
		HEAD_E = 2'd1,
		HEAD_S = 2'd2,
		HEAD_W = 2'd3
	} heading_t;

	// Scroll direction of the map contents along one axis. SHIFT_TO_LOW moves
	// every line toward index zero and clears the highest line; SHIFT_TO_HIGH
	// moves every line away from zero and clears line zero.
	typedef enum logic [1:0] {
		SHIFT_NONE    = 2'd0,
		SHIFT_TO_LOW  = 2'd1,
		SHIFT_TO_HIGH = 2'd2
	} shift_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SWEEP  = 2'd1,
		ST_READ   = 2'd2,
		ST_FINISH = 2'd3
	} state_t;

	// Command from the action sequencer to the sweep engine.
	typedef struct packed {
		logic       clear;
		logic       rec_start;
		logic       rd_start;
		shift_t     shift_x;
		shift_t     shift_y;
		logic [3:0] nbr_en;
	} sweep_cmd_t;

	// Status from the sweep engine.
	typedef struct packed {
		logic done;
		logic driveable;
		logic explored;
	} sweep_sts_t;

endpackage

// File: rtl/core/gmt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module gmt_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/gmt_sweep.sv
// Plane memory and column sweep engine of the grid map tracker.
// Depends on gmt_pkg and gmt_ram.
module gmt_sweep #(
	parameter int GRID_SIDE = 17
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gmt_pkg::sweep_cmd_t          cmd,
	input  logic [$clog2(GRID_SIDE)-1:0] col,
	input  logic [$clog2(GRID_SIDE)-1:0] row,
	input  logic [$clog2(GRID_SIDE)-1:0] rd_col,
	input  logic [$clog2(GRID_SIDE)-1:0] rd_row,
	output gmt_pkg::sweep_sts_t          sts
);
	import gmt_pkg::*;

	localparam int AW = $clog2(GRID_SIDE);
	localparam int W  = 2 * GRID_SIDE;
	localparam logic [AW-1:0] EDGE_HI = AW'(GRID_SIDE - 1);
	localparam logic [AW-1:0] MID_POS = AW'(GRID_SIDE / 2);
	localparam logic [GRID_SIDE-1:0] ONE_MID = GRID_SIDE'(1) << (GRID_SIDE / 2);

	// One memory word per column: driveable rows low, explored rows high.
	logic                 active_q;
	logic [AW-1:0]        cnt_q;
	shift_t               sx_q;
	shift_t               sy_q;
	logic [3:0]           en_q;
	logic [GRID_SIDE-1:0] valid_q;

	logic                 wr_s1;
	logic                 last_s1;
	logic                 rd_s1;
	logic [AW-1:0]        dest_s1;
	logic [AW-1:0]        addr_s1;
	logic                 zero_s1;
	logic                 vbit_s1;
	logic [AW-1:0]        rdrow_s1;

	logic [AW-1:0]        dest_i;
	logic [AW-1:0]        src_i;
	logic                 zero_i;
	logic [AW-1:0]        raddr;
	logic [W-1:0]         rdata;
	logic [W-1:0]         word_s1;
	logic [W-1:0]         wdata;
	logic [GRID_SIDE-1:0] drv_old;
	logic [GRID_SIDE-1:0] exp_old;
	logic [GRID_SIDE-1:0] drv_new;
	logic [GRID_SIDE-1:0] exp_new;
	logic [GRID_SIDE-1:0] drv_mask;
	logic [GRID_SIDE-1:0] exp_mask;
	logic [GRID_SIDE-1:0] row_hot;
	logic [GRID_SIDE-1:0] rd_exp;
	logic [AW:0]          col_wide;
	logic [AW:0]          dest_wide;

	// Walk order keeps every source column unread-before-overwritten: an
	// upward scroll walks from the top column down, the others walk up.
	always_comb begin
		dest_i = (sx_q == SHIFT_TO_HIGH) ? (EDGE_HI - cnt_q) : cnt_q;
		unique case (sx_q)
			SHIFT_TO_LOW: begin
				src_i  = dest_i + AW'(1);
				zero_i = (dest_i == EDGE_HI);
			end
			SHIFT_TO_HIGH: begin
				src_i  = dest_i - AW'(1);
				zero_i = (dest_i == '0);
			end
			default: begin
				src_i  = dest_i;
				zero_i = 1'b0;
			end
		endcase
		raddr = active_q ? src_i : rd_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			wr_s1    <= 1'b0;
			last_s1  <= 1'b0;
			rd_s1    <= 1'b0;
			valid_q  <= '0;
		end else begin
			if (cmd.rec_start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + AW'(1);
				if (cnt_q == EDGE_HI) begin
					active_q <= 1'b0;
				end
			end
			wr_s1   <= active_q;
			last_s1 <= active_q && (cnt_q == EDGE_HI);
			rd_s1   <= cmd.rd_start;
			if (cmd.clear) begin
				valid_q <= '0;
			end else if (wr_s1) begin
				valid_q[dest_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rec_start) begin
			sx_q <= cmd.shift_x;
			sy_q <= cmd.shift_y;
			en_q <= cmd.nbr_en;
		end
		dest_s1  <= dest_i;
		addr_s1  <= raddr;
		zero_s1  <= zero_i;
		vbit_s1  <= valid_q[raddr];
		rdrow_s1 <= rd_row;
	end

	gmt_ram #(
		.WIDTH(W),
		.DEPTH(GRID_SIDE)
	) u_ram (
		.clk  (clk),
		.we   (wr_s1),
		.waddr(dest_s1),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// A column never written since the last map reset reads as its reset value.
	always_comb begin
		if (vbit_s1) begin
			word_s1 = rdata;
		end else if (addr_s1 == MID_POS) begin
			word_s1 = {ONE_MID, ONE_MID};
		end else begin
			word_s1 = '0;
		end
		drv_old = zero_s1 ? '0 : word_s1[GRID_SIDE-1:0];
		exp_old = zero_s1 ? '0 : word_s1[W-1:GRID_SIDE];
		unique case (sy_q)
			SHIFT_TO_LOW: begin
				drv_new = drv_old >> 1;
				exp_new = exp_old >> 1;
			end
			SHIFT_TO_HIGH: begin
				drv_new = drv_old << 1;
				exp_new = exp_old << 1;
			end
			default: begin
				drv_new = drv_old;
				exp_new = exp_old;
			end
		endcase

		// The robot sits off the edges after the scroll, so every neighbour
		// lies inside the grid.
		row_hot   = GRID_SIDE'(1) << row;
		col_wide  = {1'b0, col};
		dest_wide = {1'b0, dest_s1};
		drv_mask  = '0;
		exp_mask  = '0;
		if (dest_s1 == col) begin
			exp_mask = row_hot;
			drv_mask = row_hot;
			if (en_q[HEAD_N]) begin
				drv_mask = drv_mask | (row_hot << 1);
			end
			if (en_q[HEAD_S]) begin
				drv_mask = drv_mask | (row_hot >> 1);
			end
		end
		if (en_q[HEAD_E] && (dest_wide == col_wide + (AW+1)'(1))) begin
			drv_mask = drv_mask | row_hot;
		end
		if (en_q[HEAD_W] && (dest_wide + (AW+1)'(1) == col_wide)) begin
			drv_mask = drv_mask | row_hot;
		end
		wdata  = {exp_new | exp_mask, drv_new | drv_mask};
		rd_exp = word_s1[W-1:GRID_SIDE];
	end

	assign sts.done      = wr_s1 & last_s1;
	assign sts.driveable = rd_s1 & word_s1[rdrow_s1];
	assign sts.explored  = rd_s1 & rd_exp[rdrow_s1];

endmodule

// File: rtl/core/robot_grid_map_tracker.sv
// Top level of the grid map tracker: action sequencer, robot pose and result register.
// Depends on gmt_pkg and gmt_sweep.

// The block keeps a robot-centred occupancy map of GRID_SIDE by GRID_SIDE cells,
// each holding a driveable and an explored bit, together with the robot's cell
// and heading. Every transfer on the input stream is one action, and each action
// yields exactly one transfer on the output stream carrying the pose after the
// action and, for a read, the two bits of the queried cell. The map lives in one
// memory with a word per column, so a read costs one memory access and a record
// walks every column once, scrolling the map when the robot stands on an edge and
// marking the current cell and, when asked, its wall-free neighbours on the way.
// Reset map, turn, advance, unused action codes and reads outside the grid go
// from the idle state straight to the finish state, where the result waits for the
// output register; a read inside the grid passes through the read state first, and a
// record through the sweep state, where the single write port of the map memory
// writes one column per cycle. One action is in flight at a time; the next input
// transfer is taken as soon as the previous action is done, even while its
// result still waits in the output register. A map reset needs no clearing pass:
// per-column valid flags make unwritten columns read as their reset contents.
module robot_grid_map_tracker #(
	parameter int GRID_SIDE = 17
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// action[2:0], turn_kind[4:3], wall_left[5], wall_front[6], wall_right[7],
	// mark_neighbours[8], query_x[13:9], query_y[18:14], zero[23:19]
	input  logic [gmt_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// pos_x[4:0], pos_y[9:5], heading[11:10], cell_driveable[12],
	// cell_explored[13], zero[15:14]
	output logic [gmt_pkg::OUT_W-1:0] m_tdata
);
	import gmt_pkg::*;

	localparam int AW = $clog2(GRID_SIDE);
	localparam logic [AW-1:0] EDGE_HI = AW'(GRID_SIDE - 1);
	localparam logic [AW-1:0] MID_POS = AW'(GRID_SIDE / 2);

	// Input fields.
	action_t    in_action;
	turn_t      in_turn;
	logic       in_wall_l;
	logic       in_wall_f;
	logic       in_wall_r;
	logic       in_mark;
	logic [4:0] in_qx;
	logic [4:0] in_qy;
	logic       in_range;

	assign in_action = action_t'(s_tdata[2:0]);
	assign in_turn   = turn_t'(s_tdata[4:3]);
	assign in_wall_l = s_tdata[5];
	assign in_wall_f = s_tdata[6];
	assign in_wall_r = s_tdata[7];
	assign in_mark   = s_tdata[8];
	assign in_qx     = s_tdata[13:9];
	assign in_qy     = s_tdata[18:14];
	assign in_range  = ({2'b00, in_qx} < 7'(GRID_SIDE)) && ({2'b00, in_qy} < 7'(GRID_SIDE));

	state_t     state_q;
	state_t     state_d;
	logic [AW-1:0] col_q;
	logic [AW-1:0] col_d;
	logic [AW-1:0] row_q;
	logic [AW-1:0] row_d;
	heading_t   heading_q;
	heading_t   heading_d;
	logic [1:0] cell_bits_q;
	logic [1:0] cell_bits_d;
	logic       out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic       out_load;
	sweep_cmd_t cmd;
	sweep_sts_t sts;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		state_d     = state_q;
		col_d       = col_q;
		row_d       = row_q;
		heading_d   = heading_q;
		cell_bits_d = cell_bits_q;
		out_load    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cell_bits_d = '0;
					state_d     = ST_FINISH;
					unique case (in_action)
						ACT_RESET: begin
							cmd.clear = 1'b1;
							col_d     = MID_POS;
							row_d     = MID_POS;
							heading_d = HEAD_N;
						end
						ACT_TURN: begin
							unique case (in_turn)
								TURN_RIGHT: heading_d = heading_t'(heading_q + 2'd1);
								TURN_LEFT:  heading_d = heading_t'(heading_q - 2'd1);
								TURN_ABOUT: heading_d = heading_t'(heading_q + 2'd2);
								default:    heading_d = heading_q;
							endcase
						end
						ACT_ADVANCE: begin
							// The robot stays put when the step would leave the grid.
							unique case (heading_q)
								HEAD_N: if (row_q != EDGE_HI) row_d = row_q + AW'(1);
								HEAD_E: if (col_q != EDGE_HI) col_d = col_q + AW'(1);
								HEAD_S: if (row_q != '0) row_d = row_q - AW'(1);
								default: if (col_q != '0) col_d = col_q - AW'(1);
							endcase
						end
						ACT_RECORD: begin
							// Scroll one cell away from any edge the robot stands on; the
							// pose moves with the map before the sweep starts.
							if (row_q == EDGE_HI) begin
								cmd.shift_y = SHIFT_TO_LOW;
								row_d       = row_q - AW'(1);
							end else if (row_q == '0) begin
								cmd.shift_y = SHIFT_TO_HIGH;
								row_d       = row_q + AW'(1);
							end
							if (col_q == EDGE_HI) begin
								cmd.shift_x = SHIFT_TO_LOW;
								col_d       = col_q - AW'(1);
							end else if (col_q == '0) begin
								cmd.shift_x = SHIFT_TO_HIGH;
								col_d       = col_q + AW'(1);
							end
							// Neighbour enables by compass direction: left is the heading
							// minus one, right the heading plus one.
							for (int d = 0; d < 4; d++) begin
								cmd.nbr_en[d] = in_mark &&
									((2'(d) == heading_q && !in_wall_f) ||
									 (2'(d) == 2'(heading_q - 2'd1) && !in_wall_l) ||
									 (2'(d) == 2'(heading_q + 2'd1) && !in_wall_r));
							end
							cmd.rec_start = 1'b1;
							state_d       = ST_SWEEP;
						end
						ACT_READ: begin
							if (in_range) begin
								cmd.rd_start = 1'b1;
								state_d      = ST_READ;
							end
						end
						default: begin
							// Unused codes only report the pose.
						end
					endcase
				end
			end
			ST_SWEEP: begin
				if (sts.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_READ: begin
				cell_bits_d = {sts.explored, sts.driveable};
				state_d     = ST_FINISH;
			end
			default: begin
				// Hand the result over once the output register is free.
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= MID_POS;
			row_q       <= MID_POS;
			heading_q   <= HEAD_N;
			cell_bits_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			col_q       <= col_d;
			row_q       <= row_d;
			heading_q   <= heading_d;
			cell_bits_q <= cell_bits_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Positions wider than five bits are reported modulo 32.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {2'b00, cell_bits_q, heading_q, 5'(row_q), 5'(col_q)};
		end
	end

	gmt_sweep #(
		.GRID_SIDE(GRID_SIDE)
	) u_sweep (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.col   (col_q),
		.row   (row_q),
		.rd_col(AW'(in_qx)),
		.rd_row(AW'(in_qy)),
		.sts   (sts)
	);

endmodule

// File: rtl/core/gmt_checks.sv
// Port-level checker for the grid map tracker and its bind to the top level.
// Depends on gmt_pkg and robot_grid_map_tracker.
module gmt_checks #(
	parameter int GRID_SIDE = 17
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [gmt_pkg::IN_W-1:0]  s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [gmt_pkg::OUT_W-1:0] m_tdata
);
	import gmt_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Only one action is in flight: ready drops after each transfer.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second action accepted while busy");

	// A map reset with a free output reports the centre cell facing north.
	a_reset_pose: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata[2:0] == 3'(ACT_RESET)) && (!m_tvalid || m_tready)
		|-> ##2 (m_tvalid && (m_tdata[4:0] == 5'(GRID_SIDE / 2)) &&
			(m_tdata[9:5] == 5'(GRID_SIDE / 2)) && (m_tdata[11:10] == 2'(HEAD_N))))
		else $error("map reset did not report the centre pose");

	// The reported pose lies inside the grid whenever the grid is at most 32 cells a side.
	a_pose_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (GRID_SIDE > 32) ||
			(({1'b0, m_tdata[4:0]} < 6'(GRID_SIDE)) && ({1'b0, m_tdata[9:5]} < 6'(GRID_SIDE))))
		else $error("reported pose outside the grid");

endmodule

bind robot_grid_map_tracker gmt_checks #(.GRID_SIDE(GRID_SIDE)) u_gmt_checks (.*);

// File: sim/tb.sv
// Self-checking testbench for robot_grid_map_tracker: random action streams on the input, an
// in-bench grid and pose tracker that predicts every result, and a field-by-field result check.
// Depends on gmt_pkg and the RTL of the tracker; reads no files.
module tb;
	import gmt_pkg::*;

	localparam int GRID       = 17;
	localparam int ITEM_GOAL  = 1500;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_LEN   = 300;

	// One action as it is staged for the driver; drain marks a pause until all results are in.
	typedef struct packed {
		logic       drain;
		logic [2:0] action;
		turn_t      kind;
		logic       wall_l;
		logic       wall_f;
		logic       wall_r;
		logic       mark;
		logic [4:0] qx;
		logic [4:0] qy;
	} map_cmd_t;

	typedef struct packed {
		logic [4:0] pos_x;
		logic [4:0] pos_y;
		heading_t   head;
		logic       drive;
		logic       seen;
	} map_pose_t;

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;

	// Handshakes seen at the last rising edge, for the processes that act on the falling edge.
	logic s_fire = 1'b0;
	logic m_fire = 1'b0;

	map_cmd_t  action_queue [$];
	map_pose_t pose_due [$];

	// Tracker state: planes are indexed [column][row], origin at the lower left.
	logic     drv_map  [GRID][GRID];
	logic     seen_map [GRID][GRID];
	int       rob_col;
	int       rob_row;
	heading_t rob_head;

	int fail_count;
	int staged;
	int n_taken;
	int n_records;
	int n_scrolls;
	int n_reads;
	int n_reads_off;
	int n_resets;
	int n_unused;

	robot_grid_map_tracker #(.GRID_SIDE(GRID)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ---------------------------------------------------------------- tracker

	task automatic clear_map();
		for (int i = 0; i < GRID; i++) begin
			for (int j = 0; j < GRID; j++) begin
				drv_map[i][j]  = 1'b0;
				seen_map[i][j] = 1'b0;
			end
		end
		drv_map[GRID/2][GRID/2]  = 1'b1;
		seen_map[GRID/2][GRID/2] = 1'b1;
		rob_col  = GRID / 2;
		rob_row  = GRID / 2;
		rob_head = HEAD_N;
	endtask

	// Moves the map contents by (mx, my) cells and clears what enters; the robot moves along.
	task automatic scroll_map(input int mx, input int my);
		logic td [GRID][GRID];
		logic te [GRID][GRID];
		int   si;
		int   sj;
		for (int i = 0; i < GRID; i++) begin
			for (int j = 0; j < GRID; j++) begin
				si = i - mx;
				sj = j - my;
				if (si >= 0 && si < GRID && sj >= 0 && sj < GRID) begin
					td[i][j] = drv_map[si][sj];
					te[i][j] = seen_map[si][sj];
				end else begin
					td[i][j] = 1'b0;
					te[i][j] = 1'b0;
				end
			end
		end
		drv_map  = td;
		seen_map = te;
		rob_col += mx;
		rob_row += my;
		n_scrolls++;
	endtask

	task automatic mark_drive(input int cx, input int cy);
		if (cx >= 0 && cx < GRID && cy >= 0 && cy < GRID)
			drv_map[cx][cy] = 1'b1;
	endtask

	task automatic track_action(input map_cmd_t c, output map_pose_t p);
		int xd;
		int yd;
		int nx;
		int ny;
		p.drive = 1'b0;
		p.seen  = 1'b0;
		xd = 0;
		yd = 0;
		case (rob_head)
			HEAD_N: yd = 1;
			HEAD_E: xd = 1;
			HEAD_S: yd = -1;
			default: xd = -1;
		endcase
		case (c.action)
			ACT_RESET: begin
				clear_map();
				n_resets++;
			end
			ACT_TURN: begin
				case (c.kind)
					TURN_RIGHT: rob_head = heading_t'(rob_head + 2'd1);
					TURN_LEFT:  rob_head = heading_t'(rob_head + 2'd3);
					TURN_ABOUT: rob_head = heading_t'(rob_head + 2'd2);
					default: ;
				endcase
			end
			ACT_ADVANCE: begin
				nx = rob_col + xd;
				ny = rob_row + yd;
				if (nx >= 0 && nx < GRID) rob_col = nx;
				if (ny >= 0 && ny < GRID) rob_row = ny;
			end
			ACT_RECORD: begin
				// Edges are tested in order top, right, bottom, left, each on the updated position.
				if (rob_row == GRID - 1) scroll_map(0, -1);
				if (rob_col == GRID - 1) scroll_map(-1, 0);
				if (rob_row == 0) scroll_map(0, 1);
				if (rob_col == 0) scroll_map(1, 0);
				mark_drive(rob_col, rob_row);
				seen_map[rob_col][rob_row] = 1'b1;
				if (c.mark) begin
					if (!c.wall_l) mark_drive(rob_col - yd, rob_row + xd);
					if (!c.wall_f) mark_drive(rob_col + xd, rob_row + yd);
					if (!c.wall_r) mark_drive(rob_col + yd, rob_row - xd);
				end
				n_records++;
			end
			ACT_READ: begin
				n_reads++;
				if (c.qx < GRID && c.qy < GRID) begin
					p.drive = drv_map[c.qx][c.qy];
					p.seen  = seen_map[c.qx][c.qy];
				end else begin
					n_reads_off++;
				end
			end
			default: n_unused++;
		endcase
		p.pos_x = rob_col[4:0];
		p.pos_y = rob_row[4:0];
		p.head  = rob_head;
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic map_cmd_t rand_cmd(input logic [2:0] act);
		map_cmd_t c;
		c.drain  = 1'b0;
		c.action = act;
		c.kind   = turn_t'($urandom_range(0, 3));
		c.wall_l = 1'($urandom_range(0, 1));
		c.wall_f = 1'($urandom_range(0, 1));
		c.wall_r = 1'($urandom_range(0, 1));
		c.mark   = 1'($urandom_range(0, 1));
		// Mostly cells inside the grid, sometimes anywhere the field reaches.
		if ($urandom_range(0, 6) != 0) begin
			c.qx = 5'($urandom_range(0, GRID - 1));
			c.qy = 5'($urandom_range(0, GRID - 1));
		end else begin
			c.qx = 5'($urandom_range(0, 31));
			c.qy = 5'($urandom_range(0, 31));
		end
		return c;
	endfunction

	task automatic stage(input map_cmd_t c);
		action_queue.push_back(c);
		if (!c.drain) staged++;
	endtask

	task automatic stage_read(input int x, input int y);
		map_cmd_t c;
		c    = rand_cmd(ACT_READ);
		c.qx = 5'(x);
		c.qy = 5'(y);
		stage(c);
	endtask

	task automatic stage_turn(input turn_t k);
		map_cmd_t c;
		c      = rand_cmd(ACT_TURN);
		c.kind = k;
		stage(c);
	endtask

	task automatic stage_record(input logic m, input logic [2:0] walls);
		map_cmd_t c;
		c        = rand_cmd(ACT_RECORD);
		c.mark   = m;
		c.wall_l = walls[2];
		c.wall_f = walls[1];
		c.wall_r = walls[0];
		stage(c);
	endtask

	initial begin
		map_cmd_t c;
		int       r;
		int       next_drain;
		clear_map();
		fail_count  = 0;
		staged      = 0;
		n_taken     = 0;
		n_records   = 0;
		n_scrolls   = 0;
		n_reads     = 0;
		n_reads_off = 0;
		n_resets    = 0;
		n_unused    = 0;

		// Directed opening: reads at and beyond the grid, unused codes, every turn,
		// a run into the bottom edge that saturates, and a record there that scrolls.
		stage_read(GRID / 2, GRID / 2);
		stage_read(31, 31);
		stage_read(GRID, 0);
		stage_read(0, GRID - 1);
		for (int a = 5; a <= 7; a++) stage(rand_cmd(3'(a)));
		stage_turn(TURN_RIGHT);
		stage_turn(TURN_LEFT);
		stage_turn(TURN_ABOUT);
		stage_turn(TURN_HOLD);
		repeat (GRID / 2 + 1) stage(rand_cmd(ACT_ADVANCE));
		stage_record(1'b1, 3'b000);
		stage_read(GRID / 2, 1);
		stage_record(1'b1, 3'b111);
		stage(rand_cmd(ACT_RESET));
		stage_record(1'b0, 3'b000);
		stage_read(GRID / 2, GRID / 2 + 1);

		// Random part: mostly walks (turn, a run of advances with records, then reads),
		// with some map resets and arbitrary noise actions in between.
		next_drain = 300;
		while (staged < ITEM_GOAL) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				stage(rand_cmd(ACT_RESET));
			end else if (r < 9) begin
				c    = rand_cmd(3'($urandom_range(0, 7)));
				c.qx = 5'($urandom_range(0, 31));
				c.qy = 5'($urandom_range(0, 31));
				stage(c);
			end else begin
				stage(rand_cmd(ACT_TURN));
				repeat ($urandom_range(1, 11)) begin
					stage(rand_cmd(ACT_ADVANCE));
					if ($urandom_range(0, 3) == 0)
						stage_record($urandom_range(0, 4) != 0, 3'($urandom_range(0, 7)));
				end
				stage_record($urandom_range(0, 4) != 0, 3'($urandom_range(0, 7)));
				repeat ($urandom_range(0, 2)) stage(rand_cmd(ACT_READ));
			end
			if (staged >= next_drain) begin
				c       = rand_cmd(ACT_READ);
				c.drain = 1'b1;
				stage(c);
				next_drain += 300;
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (action_queue.size() != 0 || s_tvalid) @(posedge clk);
		while (pose_due.size() != 0) @(posedge clk);
		repeat (GRID + 8) @(posedge clk);

		$display("Covered %0d actions: %0d records with %0d map scrolls, %0d map resets,",
			n_taken, n_records, n_scrolls, n_resets);
		$display("%0d reads (%0d outside the grid) and %0d unused action codes.",
			n_reads, n_reads_off, n_unused);
		if (fail_count == 0 && pose_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// ---------------------------------------------------------------- driver

	int  tx_gap  = 0;
	bit  tx_calm = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_fire) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (action_queue.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (action_queue[0].drain) begin
					// Pause until every result in flight has come back.
					if (pose_due.size() == 0) action_queue.delete(0);
					s_tvalid <= 1'b0;
				end else begin
					s_tdata <= {5'b0, action_queue[0].qy, action_queue[0].qx,
						action_queue[0].mark, action_queue[0].wall_r, action_queue[0].wall_f,
						action_queue[0].wall_l, action_queue[0].kind, action_queue[0].action};
					s_tvalid <= 1'b1;
					action_queue.delete(0);
					if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
					tx_gap = tx_calm ? 0 : $urandom_range(0, 8);
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	int rx_wait  = 0;
	int rx_taken = 0;
	bit rx_calm  = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (m_fire) begin
				rx_taken++;
				if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
				// Long hold-offs let the block back up and stall its input.
				if (rx_taken % 700 == 400) rx_wait = HOLD_LEN;
				else rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
			end
			if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	map_cmd_t  taken;
	map_pose_t want;
	map_pose_t got;

	always @(posedge clk) begin
		if (arst_n) begin
			s_fire <= s_tvalid && s_tready;
			m_fire <= m_tvalid && m_tready;
			if (m_tvalid && m_tready) begin
				got.pos_x = m_tdata[4:0];
				got.pos_y = m_tdata[9:5];
				got.head  = heading_t'(m_tdata[11:10]);
				got.drive = m_tdata[12];
				got.seen  = m_tdata[13];
				if (pose_due.size() == 0) begin
					$error("result transfer with no action outstanding");
					fail_count++;
				end else begin
					want = pose_due.pop_front();
					if (got.pos_x !== want.pos_x) begin
						$error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
						fail_count++;
					end
					if (got.pos_y !== want.pos_y) begin
						$error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
						fail_count++;
					end
					if (got.head !== want.head) begin
						$error("heading: expected %0d, got %0d", want.head, got.head);
						fail_count++;
					end
					if (got.drive !== want.drive) begin
						$error("cell_driveable: expected %0d, got %0d", want.drive, got.drive);
						fail_count++;
					end
					if (got.seen !== want.seen) begin
						$error("cell_explored: expected %0d, got %0d", want.seen, got.seen);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				taken.drain  = 1'b0;
				taken.action = s_tdata[2:0];
				taken.kind   = turn_t'(s_tdata[4:3]);
				taken.wall_l = s_tdata[5];
				taken.wall_f = s_tdata[6];
				taken.wall_r = s_tdata[7];
				taken.mark   = s_tdata[8];
				taken.qx     = s_tdata[13:9];
				taken.qy     = s_tdata[18:14];
				track_action(taken, want);
				pose_due.push_back(want);
				n_taken++;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule
